FILE: rtl/fsp_pkg.sv
// fsp_pkg: shared types, constants and register map of the framed sensor poll master.
// No dependencies; used by every file under rtl/.
package fsp_pkg;

    // Frame geometry
    localparam int FRAME_LEN    = 6;
    localparam int REQ_LEN      = 6;
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int STORE_DEPTH  = FRAME_LEN - 1;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam int BEAT_W       = $clog2(REQ_LEN);

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_ID     = 3'd0,
        REG_FUNCTION_CODE = 3'd1,
        REG_START_BYTE    = 3'd2,
        REG_END_BYTE      = 3'd3,
        REG_REQUEST_WORD  = 3'd4
    } t_reg_idx;

    localparam logic [7:0]  RST_SENSOR_ID     = 8'h02;
    localparam logic [7:0]  RST_FUNCTION_CODE = 8'h02;
    localparam logic [7:0]  RST_START_BYTE    = 8'h3A;
    localparam logic [7:0]  RST_END_BYTE      = 8'h0D;
    localparam logic [15:0] RST_REQUEST_WORD  = 16'h0002;

    // Input item kinds
    typedef enum logic {
        CMD_RX_BYTE = 1'b0,
        CMD_BUTTON  = 1'b1
    } t_cmd;

    // Frame outcome reported with each result
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } t_frame_status;

    // Request frame positions
    typedef enum logic [BEAT_W-1:0] {
        REQ_POS_START = 3'd0,
        REQ_POS_ID    = 3'd1,
        REQ_POS_FUNC  = 3'd2,
        REQ_POS_HIGH  = 3'd3,
        REQ_POS_LOW   = 3'd4,
        REQ_POS_END   = 3'd5
    } t_req_pos;

    typedef struct packed {
        logic [7:0]  sensor_id;
        logic [7:0]  function_code;
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] request_word;
    } t_cfg;

    // One queued job: a request burst or a single status result
    typedef struct packed {
        logic          is_req;
        logic [15:0]   distance;
        t_frame_status status;
    } t_job;

    // Queue handshake seen by the front
    typedef struct packed {
        logic push;
        t_job job;
    } t_q_wr;

endpackage

FILE: rtl/fsp_ifs.sv
// fsp_ifs: valid/ready channel interfaces for input items, result items and config writes.
// Depends on fsp_pkg.
interface fsp_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic [7:0] rx_byte;
    logic button_level;
    modport source (output valid, cmd, rx_byte, button_level, input ready);
    modport sink   (input valid, cmd, rx_byte, button_level, output ready);
endinterface

interface fsp_out_if;
    logic valid;
    logic ready;
    logic tx_valid;
    logic [7:0] tx_byte;
    logic last;
    logic [15:0] distance;
    logic [1:0] frame_status;
    modport source (output valid, tx_valid, tx_byte, last, distance, frame_status,
                    input ready);
    modport sink   (input valid, tx_valid, tx_byte, last, distance, frame_status,
                    output ready);
endinterface

interface fsp_cfg_if;
    logic valid;
    logic ready;
    logic [fsp_pkg::CFG_IDX_W-1:0] index;
    logic [fsp_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fsp_front.sv
// fsp_front: accepts input items, runs edge detect and deframing, queues one job per item.
// Depends on fsp_pkg and fsp_ifs.
module fsp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fsp_in_if.sink           i_in,
    input  fsp_pkg::t_cfg    i_cfg,
    input  logic             i_q_full,
    output fsp_pkg::t_q_wr   o_q_wr
);

    localparam logic [fsp_pkg::POS_W-1:0] POS_LAST = fsp_pkg::POS_W'(fsp_pkg::FRAME_LEN - 1);

    logic [fsp_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_btn_prev, n_btn_prev;
    logic [15:0]               r_dist, n_dist;
    logic [7:0]                r_store [fsp_pkg::STORE_DEPTH];
    logic                      store_we;
    logic                      accept;
    fsp_pkg::t_job             job;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_pos      = r_pos;
        n_btn_prev = r_btn_prev;
        n_dist     = r_dist;
        store_we   = 1'b0;
        job.is_req = 1'b0;
        job.status = fsp_pkg::ST_NONE;
        if (fsp_pkg::t_cmd'(i_in.cmd) == fsp_pkg::CMD_BUTTON) begin
            if (i_in.button_level && !r_btn_prev) begin
                // rising edge: request burst, held distance cleared
                n_btn_prev = 1'b1;
                n_dist     = 16'd0;
                job.is_req = 1'b1;
            end else if (!i_in.button_level) begin
                n_btn_prev = 1'b0;
            end
        end else begin
            if (r_pos == '0) begin
                // hunting for the start delimiter
                if (i_in.rx_byte == i_cfg.start_byte) begin
                    store_we = 1'b1;
                    n_pos    = r_pos + 1'b1;
                end
            end else if (r_pos >= POS_LAST) begin
                if (r_store[1] == i_cfg.sensor_id && i_in.rx_byte == i_cfg.end_byte) begin
                    n_dist     = {r_store[3], r_store[4]};
                    job.status = fsp_pkg::ST_ACCEPT;
                end else begin
                    job.status = fsp_pkg::ST_REJECT;
                end
                n_pos = '0;
            end else begin
                store_we = 1'b1;
                n_pos    = r_pos + 1'b1;
            end
        end
        job.distance = n_dist;
    end

    assign o_q_wr.push = accept;
    assign o_q_wr.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_btn_prev <= 1'b0;
            r_dist     <= 16'd0;
        end else if (accept) begin
            r_pos      <= n_pos;
            r_btn_prev <= n_btn_prev;
            r_dist     <= n_dist;
        end
    end

    // frame bytes: no reset, every checked byte is written earlier in its frame
    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_store[r_pos[fsp_pkg::STORE_IDX_W-1:0]] <= i_in.rx_byte;
        end
    end

endmodule

FILE: rtl/fsp_queue.sv
// fsp_queue: small job FIFO between the front and the back.
// Depends on fsp_pkg.
module fsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsp_pkg::t_q_wr  i_wr,
    output logic            o_full,
    output logic            o_valid,
    output fsp_pkg::t_job   o_job,
    input  logic            i_pop
);

    fsp_pkg::t_job                   r_mem [fsp_pkg::Q_DEPTH];
    logic [fsp_pkg::Q_PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [fsp_pkg::Q_CNT_W-1:0]     r_count;
    logic                            do_push, do_pop;

    assign o_full  = (r_count == fsp_pkg::Q_CNT_W'(fsp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

endmodule

FILE: rtl/fsp_back.sv
// fsp_back: expands queued jobs into result transfers through an output register.
// Depends on fsp_pkg and fsp_ifs.
module fsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsp_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  fsp_pkg::t_job   i_job,
    output logic            o_pop,
    fsp_out_if.source       o_out
);

    localparam logic [fsp_pkg::BEAT_W-1:0] BEAT_LAST = fsp_pkg::BEAT_W'(fsp_pkg::REQ_LEN - 1);

    logic [fsp_pkg::BEAT_W-1:0] r_beat, n_beat;
    logic                       r_valid;
    logic                       r_tx_valid, r_last;
    logic [7:0]                 r_tx_byte;
    logic [15:0]                r_dist;
    fsp_pkg::t_frame_status     r_status;
    logic                       load;
    logic                       beat_last;
    logic [7:0]                 req_byte;

    assign load      = (!r_valid || o_out.ready) && i_q_valid;
    assign beat_last = (r_beat == BEAT_LAST);
    assign o_pop     = load && (!i_job.is_req || beat_last);

    always_comb begin
        case (fsp_pkg::t_req_pos'(r_beat))
            fsp_pkg::REQ_POS_START: req_byte = i_cfg.start_byte;
            fsp_pkg::REQ_POS_ID:    req_byte = i_cfg.sensor_id;
            fsp_pkg::REQ_POS_FUNC:  req_byte = i_cfg.function_code;
            fsp_pkg::REQ_POS_HIGH:  req_byte = i_cfg.request_word[15:8];
            fsp_pkg::REQ_POS_LOW:   req_byte = i_cfg.request_word[7:0];
            fsp_pkg::REQ_POS_END:   req_byte = i_cfg.end_byte;
            default:                req_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_beat = r_beat;
        if (load && i_job.is_req) begin
            n_beat = beat_last ? '0 : r_beat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_beat <= n_beat;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_valid <= i_job.is_req;
            r_tx_byte  <= i_job.is_req ? req_byte : 8'd0;
            r_last     <= !i_job.is_req || beat_last;
            r_dist     <= i_job.distance;
            r_status   <= i_job.status;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.tx_valid     = r_tx_valid;
    assign o_out.tx_byte      = r_tx_byte;
    assign o_out.last         = r_last;
    assign o_out.distance     = r_dist;
    assign o_out.frame_status = r_status;

endmodule

FILE: rtl/framed_sensor_poll_master_core.sv
// framed_sensor_poll_master_core: top level of the sensor poll master.
// Depends on fsp_pkg, fsp_ifs, fsp_front, fsp_queue, fsp_back.
//
//  channel   dir  payload                                         transfer when
//  -------   ---  ----------------------------------------------  -------------------------
//  i_in      in   cmd, rx_byte, button_level                      i_in.valid & i_in.ready
//  o_out     out  tx_valid, tx_byte, last, distance, frame_status o_out.valid & o_out.ready
//  i_cfg     in   index, data (register write)                    i_cfg.valid & i_cfg.ready
//
// Cycles: an input item is taken every cycle while the job queue has room; a
//   received byte or plain button sample gives one result, a button rising edge
//   gives six request bytes in order. The back end's output register sets the
//   pace: one result per cycle while o_out.ready is high and a job is queued.
// Path: the first result of an item is written into the job queue, then loaded
//   into the output register, where it is offered on o_out.
// Reset: synchronous, active low; clears frame position, edge detector, held
//   distance, queue and output valid, and loads the register defaults.
// Stalls: o_out.ready low holds the output register; the four-entry job queue
//   keeps taking items until full, then i_in.ready drops. i_cfg is always ready.
module framed_sensor_poll_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsp_in_if.sink     i_in,
    fsp_out_if.source  o_out,
    fsp_cfg_if.sink    i_cfg
);

    fsp_pkg::t_cfg  r_cfg;
    fsp_pkg::t_q_wr q_wr;
    fsp_pkg::t_job  q_job;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    // Register file: writes to indexes past the map are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_id     <= fsp_pkg::RST_SENSOR_ID;
            r_cfg.function_code <= fsp_pkg::RST_FUNCTION_CODE;
            r_cfg.start_byte    <= fsp_pkg::RST_START_BYTE;
            r_cfg.end_byte      <= fsp_pkg::RST_END_BYTE;
            r_cfg.request_word  <= fsp_pkg::RST_REQUEST_WORD;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (fsp_pkg::t_reg_idx'(i_cfg.index))
                fsp_pkg::REG_SENSOR_ID:     r_cfg.sensor_id     <= i_cfg.data[7:0];
                fsp_pkg::REG_FUNCTION_CODE: r_cfg.function_code <= i_cfg.data[7:0];
                fsp_pkg::REG_START_BYTE:    r_cfg.start_byte    <= i_cfg.data[7:0];
                fsp_pkg::REG_END_BYTE:      r_cfg.end_byte      <= i_cfg.data[7:0];
                fsp_pkg::REG_REQUEST_WORD:  r_cfg.request_word  <= i_cfg.data;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Front: edge detect, deframing, held distance; one job per input item.
    fsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // Back: request burst sequencing and the output register.
    fsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/fsp_checker.sv
// fsp_checker: port-level checks on the result channel, bound to the top level.
// Depends on fsp_pkg and framed_sensor_poll_master_core.
module fsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_tx_valid,
    input logic [7:0] i_tx_byte,
    input logic       i_last,
    input logic [15:0] i_distance,
    input logic [1:0] i_frame_status
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_tx_byte) && $stable(i_last)
                                   && $stable(i_distance) && $stable(i_frame_status)))
        else $error("result changed while stalled");

    // request burst runs without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_tx_valid && !i_last) |=> (i_valid && i_tx_valid))
        else $error("request burst broken");

    // non-request results are single and carry a zero byte
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_tx_valid) |-> (i_last && i_tx_byte == 8'd0))
        else $error("status result malformed");

    // request bytes carry no frame outcome and a cleared distance
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_tx_valid) |->
            (i_frame_status == fsp_pkg::ST_NONE && i_distance == 16'd0))
        else $error("request byte with status or distance");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind framed_sensor_poll_master_core fsp_checker u_fsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_tx_valid     (o_out.tx_valid),
    .i_tx_byte      (o_out.tx_byte),
    .i_last         (o_out.last),
    .i_distance     (o_out.distance),
    .i_frame_status (o_out.frame_status)
);
